// ===== rtl/gnms_pkg.sv =====
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared constants, types and tables for the gradient non-maximum suppression
// core.
// ----------------------------------------------------------------------------
package gnms_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int POS_W       = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
  localparam int MEM_DEPTH   = 3 * MAX_COLUMNS;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int PEND_W      = 11;
  localparam int NORM_W      = 20;
  localparam int PROD_W      = 36;
  localparam int ACC_W       = 37;
  localparam int RAD_W       = 41;
  localparam int ROOT_TOP    = 40;
  localparam int ROOT_STEPS  = 21;
  localparam int CORD_STEPS  = 20;
  localparam int CORD_W      = 34;
  localparam int ANG_W       = 25;
  localparam int CNT_W       = 5;
  localparam int MUL_STEPS   = 6;

  localparam logic [PEND_W-1:0] PEND_MAX = '1;
  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(1024);
  localparam logic signed [ANG_W-1:0] PI_UNITS = ANG_W'(8235497);

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LD, ST_SQX, ST_SQY, ST_SUM, ST_CLASS, ST_ROOT_LD,
    ST_ROOT, ST_ROOT_ST, ST_MUL, ST_KEEP, ST_CORD_LD, ST_CORD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {PH_CENTER, PH_NEIGH, PH_MAG} phase_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_XX, MUL_YY, MUL_NA, MUL_BG1, MUL_DG2, MUL_BG3, MUL_DG4
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_LHS, ACC_CMP1, ACC_CMP2
  } acc_op_t;

  typedef enum logic [1:0] {DST_N, DST_G, DST_MAG} dst_t;

  typedef enum logic [1:0] {RES_ZERO, RES_BORDER, RES_KEPT} res_kind_t;

  typedef struct packed {
    logic             accept;
    logic             rd_en;
    logic             rd_center;
    logic [1:0]       role;
    logic             cap_center;
    mul_sel_t         mul_sel;
    acc_op_t          acc_op;
    logic             save_s;
    logic             root_ld;
    logic             root_mag;
    logic             root_step;
    logic             root_st;
    dst_t             root_dst;
    logic             cord_ld;
    logic             cord_step;
    logic [CNT_W-1:0] step;
    logic             out_load;
    res_kind_t        res_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_go;
    logic border;
    logic small_grad;
    logic kept;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [ANG_W-1:0] atan_unit(input logic [CNT_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:    v = ANG_W'(2058874);
      5'd1:    v = ANG_W'(1215424);
      5'd2:    v = ANG_W'(642197);
      5'd3:    v = ANG_W'(325989);
      5'd4:    v = ANG_W'(163627);
      5'd5:    v = ANG_W'(81893);
      5'd6:    v = ANG_W'(40957);
      5'd7:    v = ANG_W'(20480);
      5'd8:    v = ANG_W'(10240);
      5'd9:    v = ANG_W'(5120);
      5'd10:   v = ANG_W'(2560);
      5'd11:   v = ANG_W'(1280);
      5'd12:   v = ANG_W'(640);
      5'd13:   v = ANG_W'(320);
      5'd14:   v = ANG_W'(160);
      5'd15:   v = ANG_W'(80);
      5'd16:   v = ANG_W'(40);
      5'd17:   v = ANG_W'(20);
      5'd18:   v = ANG_W'(10);
      5'd19:   v = ANG_W'(5);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/gnms_ctrl.sv =====
// ----------------------------------------------------------------------------
// gnms_ctrl
// Sequencer: accepts words and steps the datapath through window reads,
// squares, square roots, the suppression compare and the angle iterations.
// ----------------------------------------------------------------------------
module gnms_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  gnms_pkg::dp_status_t   status,
  output gnms_pkg::ctrl_cmd_t    cmd
);

  gnms_pkg::state_t    state_r, state_nxt;
  gnms_pkg::phase_t    phase_r, phase_nxt;
  gnms_pkg::res_kind_t res_r, res_nxt;
  logic [1:0]                 role_r, role_nxt;
  logic [gnms_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gnms_pkg::ST_IDLE;
      phase_r <= gnms_pkg::PH_CENTER;
      res_r   <= gnms_pkg::RES_ZERO;
      role_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      res_r   <= res_nxt;
      role_r  <= role_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    res_nxt   = res_r;
    role_nxt  = role_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      gnms_pkg::ST_IDLE: begin
        if (in_tvalid && status.emit_go) begin
          state_nxt = gnms_pkg::ST_RD;
          phase_nxt = gnms_pkg::PH_CENTER;
        end
      end
      gnms_pkg::ST_RD:  state_nxt = gnms_pkg::ST_LD;
      gnms_pkg::ST_LD:  state_nxt = gnms_pkg::ST_SQX;
      gnms_pkg::ST_SQX: state_nxt = gnms_pkg::ST_SQY;
      gnms_pkg::ST_SQY: state_nxt = gnms_pkg::ST_SUM;
      gnms_pkg::ST_SUM: begin
        state_nxt = (phase_r == gnms_pkg::PH_CENTER) ? gnms_pkg::ST_CLASS
                                                      : gnms_pkg::ST_ROOT_LD;
      end
      gnms_pkg::ST_CLASS: begin
        priority if (status.border) begin
          phase_nxt = gnms_pkg::PH_MAG;
          res_nxt   = gnms_pkg::RES_BORDER;
          state_nxt = gnms_pkg::ST_ROOT_LD;
        end else if (status.small_grad) begin
          res_nxt   = gnms_pkg::RES_ZERO;
          state_nxt = gnms_pkg::ST_OUT;
        end else begin
          state_nxt = gnms_pkg::ST_ROOT_LD;
        end
      end
      gnms_pkg::ST_ROOT_LD: begin
        cnt_nxt   = '0;
        state_nxt = gnms_pkg::ST_ROOT;
      end
      gnms_pkg::ST_ROOT: begin
        if (cnt_r == gnms_pkg::CNT_W'(gnms_pkg::ROOT_STEPS - 1)) begin
          state_nxt = gnms_pkg::ST_ROOT_ST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      gnms_pkg::ST_ROOT_ST: begin
        unique case (phase_r)
          gnms_pkg::PH_CENTER: begin
            phase_nxt = gnms_pkg::PH_NEIGH;
            role_nxt  = '0;
            state_nxt = gnms_pkg::ST_RD;
          end
          gnms_pkg::PH_NEIGH: begin
            if (role_r == 2'd3) begin
              cnt_nxt   = '0;
              state_nxt = gnms_pkg::ST_MUL;
            end else begin
              role_nxt  = role_r + 1'b1;
              state_nxt = gnms_pkg::ST_RD;
            end
          end
          default: begin
            state_nxt = (res_r == gnms_pkg::RES_BORDER) ? gnms_pkg::ST_OUT
                                                         : gnms_pkg::ST_CORD_LD;
          end
        endcase
      end
      gnms_pkg::ST_MUL: begin
        if (cnt_r == gnms_pkg::CNT_W'(gnms_pkg::MUL_STEPS - 1)) begin
          state_nxt = gnms_pkg::ST_KEEP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      gnms_pkg::ST_KEEP: begin
        if (status.kept) begin
          phase_nxt = gnms_pkg::PH_MAG;
          res_nxt   = gnms_pkg::RES_KEPT;
          state_nxt = gnms_pkg::ST_ROOT_LD;
        end else begin
          res_nxt   = gnms_pkg::RES_ZERO;
          state_nxt = gnms_pkg::ST_OUT;
        end
      end
      gnms_pkg::ST_CORD_LD: begin
        cnt_nxt   = '0;
        state_nxt = gnms_pkg::ST_CORD;
      end
      gnms_pkg::ST_CORD: begin
        if (cnt_r == gnms_pkg::CNT_W'(gnms_pkg::CORD_STEPS - 1)) begin
          state_nxt = gnms_pkg::ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      gnms_pkg::ST_OUT: begin
        if (status.out_free) state_nxt = gnms_pkg::ST_IDLE;
      end
      default: state_nxt = gnms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = gnms_pkg::MUL_NONE;
    cmd.acc_op    = gnms_pkg::ACC_HOLD;
    cmd.root_dst  = gnms_pkg::DST_N;
    cmd.res_kind  = res_r;
    cmd.role      = role_r;
    cmd.step      = cnt_r;
    in_tready     = 1'b0;
    unique case (state_r)
      gnms_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      gnms_pkg::ST_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_center = (phase_r == gnms_pkg::PH_CENTER);
      end
      gnms_pkg::ST_LD:  cmd.cap_center = (phase_r == gnms_pkg::PH_CENTER);
      gnms_pkg::ST_SQX: cmd.mul_sel = gnms_pkg::MUL_XX;
      gnms_pkg::ST_SQY: begin
        cmd.mul_sel = gnms_pkg::MUL_YY;
        cmd.acc_op  = gnms_pkg::ACC_LOAD;
      end
      gnms_pkg::ST_SUM: begin
        cmd.acc_op = gnms_pkg::ACC_ADD;
        cmd.save_s = (phase_r == gnms_pkg::PH_CENTER);
      end
      gnms_pkg::ST_ROOT_LD: begin
        cmd.root_ld  = 1'b1;
        cmd.root_mag = (phase_r == gnms_pkg::PH_MAG);
      end
      gnms_pkg::ST_ROOT: cmd.root_step = 1'b1;
      gnms_pkg::ST_ROOT_ST: begin
        cmd.root_st = 1'b1;
        unique case (phase_r)
          gnms_pkg::PH_CENTER: cmd.root_dst = gnms_pkg::DST_N;
          gnms_pkg::PH_NEIGH:  cmd.root_dst = gnms_pkg::DST_G;
          default:             cmd.root_dst = gnms_pkg::DST_MAG;
        endcase
      end
      gnms_pkg::ST_MUL: begin
        unique case (cnt_r)
          5'd0: cmd.mul_sel = gnms_pkg::MUL_NA;
          5'd1: begin
            cmd.mul_sel = gnms_pkg::MUL_BG1;
            cmd.acc_op  = gnms_pkg::ACC_LHS;
          end
          5'd2: begin
            cmd.mul_sel = gnms_pkg::MUL_DG2;
            cmd.acc_op  = gnms_pkg::ACC_LOAD;
          end
          5'd3: begin
            cmd.mul_sel = gnms_pkg::MUL_BG3;
            cmd.acc_op  = gnms_pkg::ACC_CMP1;
          end
          5'd4: begin
            cmd.mul_sel = gnms_pkg::MUL_DG4;
            cmd.acc_op  = gnms_pkg::ACC_LOAD;
          end
          default: cmd.acc_op = gnms_pkg::ACC_CMP2;
        endcase
      end
      gnms_pkg::ST_CORD_LD: cmd.cord_ld = 1'b1;
      gnms_pkg::ST_CORD:    cmd.cord_step = 1'b1;
      gnms_pkg::ST_OUT:     cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/gnms_datapath.sv =====
// ----------------------------------------------------------------------------
// gnms_datapath
// Line stores, position counters, shared multiplier, bit-serial square root,
// vectoring CORDIC and the output register.
// ----------------------------------------------------------------------------
module gnms_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gnms_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [gnms_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [31:0]                    in_tdata,
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,
  output logic                           out_tlast,
  input  gnms_pkg::ctrl_cmd_t            cmd,
  output gnms_pkg::dp_status_t           status
);

  localparam int PW = gnms_pkg::POS_W;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  // configuration
  logic [gnms_pkg::CFG_W-1:0] cols_r, rows_r;
  logic [PW-1:0] cols_eff, rows_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= gnms_pkg::CFG_RESET;
      rows_r <= gnms_pkg::CFG_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == gnms_pkg::CFG_COLUMNS) cols_r <= cfg_wdata;
      else rows_r <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (PW'(cols_r) < PW'(3)) cols_eff = PW'(3);
    else if (PW'(cols_r) > PW'(gnms_pkg::MAX_COLUMNS)) cols_eff = PW'(gnms_pkg::MAX_COLUMNS);
    else cols_eff = PW'(cols_r);
    priority if (PW'(rows_r) < PW'(3)) rows_eff = PW'(3);
    else if (PW'(rows_r) > PW'(gnms_pkg::MAX_ROWS)) rows_eff = PW'(gnms_pkg::MAX_ROWS);
    else rows_eff = PW'(rows_r);
  end

  // positions and pending count
  logic [gnms_pkg::COL_W-1:0]  col_cnt_r, emit_col_r;
  logic [gnms_pkg::ROW_W-1:0]  emit_row_r;
  logic [1:0]                  in_slot_r, emit_slot_r;
  logic [gnms_pkg::PEND_W-1:0] pend_r, pend_inc, pend_nxt;
  logic [PW-1:0]               col_step, ecol_step, erow_step;
  logic                        emit_go;

  assign col_step  = PW'(col_cnt_r) + PW'(1);
  assign ecol_step = PW'(emit_col_r) + PW'(1);
  assign erow_step = PW'(emit_row_r) + PW'(1);
  assign pend_inc  = (pend_r == gnms_pkg::PEND_MAX) ? pend_r : pend_r + 1'b1;

  always_comb begin
    if (in_tuser) begin
      emit_go  = (pend_r != '0);
      pend_nxt = emit_go ? pend_r - 1'b1 : pend_r;
    end else begin
      emit_go  = PW'(pend_inc) > (cols_eff + PW'(1));
      pend_nxt = emit_go ? pend_inc - 1'b1 : pend_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      in_slot_r   <= '0;
      emit_col_r  <= '0;
      emit_row_r  <= '0;
      emit_slot_r <= '0;
      pend_r      <= '0;
    end else begin
      if (cmd.accept) begin
        pend_r <= pend_nxt;
        if (!in_tuser) begin
          if (col_step >= cols_eff) begin
            col_cnt_r <= '0;
            in_slot_r <= (in_slot_r == 2'd2) ? 2'd0 : in_slot_r + 2'd1;
          end else begin
            col_cnt_r <= gnms_pkg::COL_W'(col_step);
          end
        end
      end
      if (cmd.out_load) begin
        if (ecol_step >= cols_eff) begin
          emit_col_r  <= '0;
          emit_slot_r <= (emit_slot_r == 2'd2) ? 2'd0 : emit_slot_r + 2'd1;
          emit_row_r  <= (erow_step >= rows_eff) ? '0 : gnms_pkg::ROW_W'(erow_step);
        end else begin
          emit_col_r <= gnms_pkg::COL_W'(ecol_step);
        end
      end
    end
  end

  // center pixel
  logic signed [15:0] c_gx_r, c_gy_r;
  logic [15:0]        c_ax_r, c_ay_r, a_val, b_val, d_val;
  logic               steep, pos, border, frame_end;

  assign steep  = c_ay_r > c_ax_r;
  assign pos    = (c_gx_r > 0 && c_gy_r > 0) || (c_gx_r < 0 && c_gy_r < 0);
  assign a_val  = steep ? c_ay_r : c_ax_r;
  assign b_val  = steep ? c_ax_r : c_ay_r;
  assign d_val  = a_val - b_val;
  assign border = (emit_row_r == '0) || (erow_step >= rows_eff) ||
                  (emit_col_r == '0) || (ecol_step >= cols_eff);
  assign frame_end = (erow_step == rows_eff) && (ecol_step == cols_eff);

  // line stores
  logic [31:0] mem [gnms_pkg::MEM_DEPTH];
  logic [31:0] rdata_r;
  logic [gnms_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [1:0] win_row, win_col, rd_slot;
  logic [gnms_pkg::COL_W:0] rd_col;

  always_comb begin
    win_row = 2'd1;
    win_col = 2'd1;
    if (!cmd.rd_center) begin
      unique case (cmd.role)
        2'd0: begin
          if (steep) begin win_row = 2'd0; win_col = pos ? 2'd0 : 2'd2; end
          else begin win_row = pos ? 2'd2 : 2'd0; win_col = 2'd2; end
        end
        2'd1: begin
          if (steep) begin win_row = 2'd0; win_col = 2'd1; end
          else begin win_row = 2'd1; win_col = 2'd2; end
        end
        2'd2: begin
          if (steep) begin win_row = 2'd2; win_col = pos ? 2'd2 : 2'd0; end
          else begin win_row = pos ? 2'd0 : 2'd2; win_col = 2'd0; end
        end
        default: begin
          if (steep) begin win_row = 2'd2; win_col = 2'd1; end
          else begin win_row = 2'd1; win_col = 2'd0; end
        end
      endcase
    end
    unique case (win_row)
      2'd0:    rd_slot = (emit_slot_r == 2'd0) ? 2'd2 : emit_slot_r - 2'd1;
      2'd2:    rd_slot = (emit_slot_r == 2'd2) ? 2'd0 : emit_slot_r + 2'd1;
      default: rd_slot = emit_slot_r;
    endcase
  end

  assign rd_col  = {1'b0, emit_col_r} + (gnms_pkg::COL_W + 1)'(win_col) - 1'b1;
  assign rd_addr = gnms_pkg::ADDR_W'(rd_slot) * gnms_pkg::ADDR_W'(gnms_pkg::MAX_COLUMNS) +
                   gnms_pkg::ADDR_W'(rd_col[gnms_pkg::COL_W-1:0]);
  assign wr_addr = gnms_pkg::ADDR_W'(in_slot_r) * gnms_pkg::ADDR_W'(gnms_pkg::MAX_COLUMNS) +
                   gnms_pkg::ADDR_W'(col_cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.accept && !in_tuser) mem[wr_addr] <= in_tdata;
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_center) begin
      c_gx_r <= rdata_r[15:0];
      c_gy_r <= rdata_r[31:16];
      c_ax_r <= abs16(rdata_r[15:0]);
      c_ay_r <= abs16(rdata_r[31:16]);
    end
  end

  // shared multiplier and accumulator
  logic [gnms_pkg::NORM_W-1:0] n_r, mag_src;
  logic [gnms_pkg::NORM_W-1:0] g_r [4];
  logic [gnms_pkg::NORM_W-1:0] mul_a;
  logic [15:0]                 mul_b;
  logic [gnms_pkg::PROD_W-1:0] mul_r, lhs_r;
  logic [gnms_pkg::ACC_W-1:0]  acc_r, acc_sum;
  logic [31:0]                 s_c_r;
  logic                        keep1_r, keep2_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      gnms_pkg::MUL_XX: begin
        mul_a = gnms_pkg::NORM_W'(abs16(rdata_r[15:0]));
        mul_b = abs16(rdata_r[15:0]);
      end
      gnms_pkg::MUL_YY: begin
        mul_a = gnms_pkg::NORM_W'(abs16(rdata_r[31:16]));
        mul_b = abs16(rdata_r[31:16]);
      end
      gnms_pkg::MUL_NA:  begin mul_a = n_r;    mul_b = a_val; end
      gnms_pkg::MUL_BG1: begin mul_a = g_r[0]; mul_b = b_val; end
      gnms_pkg::MUL_DG2: begin mul_a = g_r[1]; mul_b = d_val; end
      gnms_pkg::MUL_BG3: begin mul_a = g_r[2]; mul_b = b_val; end
      gnms_pkg::MUL_DG4: begin mul_a = g_r[3]; mul_b = d_val; end
      default: ;
    endcase
  end

  assign acc_sum = acc_r + gnms_pkg::ACC_W'(mul_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != gnms_pkg::MUL_NONE) mul_r <= mul_a * mul_b;
    unique case (cmd.acc_op)
      gnms_pkg::ACC_LOAD: acc_r   <= gnms_pkg::ACC_W'(mul_r);
      gnms_pkg::ACC_ADD:  acc_r   <= acc_sum;
      gnms_pkg::ACC_LHS:  lhs_r   <= mul_r;
      gnms_pkg::ACC_CMP1: keep1_r <= gnms_pkg::ACC_W'(lhs_r) > acc_sum;
      gnms_pkg::ACC_CMP2: keep2_r <= gnms_pkg::ACC_W'(lhs_r) > acc_sum;
      default: ;
    endcase
    if (cmd.save_s) s_c_r <= acc_sum[31:0];
  end

  // bit-serial square root
  logic [gnms_pkg::RAD_W-1:0] rem_r, root_r, radicand, root_bit;
  logic [gnms_pkg::RAD_W:0]   trial;
  logic [5:0]                 bit_pos;
  logic [7:0]                 mag_r, mag_sat;

  assign radicand = cmd.root_mag ? gnms_pkg::RAD_W'(s_c_r) * gnms_pkg::RAD_W'(400)
                                 : gnms_pkg::RAD_W'({acc_r[31:0], 8'd0});
  assign bit_pos  = 6'(gnms_pkg::ROOT_TOP) - {cmd.step, 1'b0};
  assign root_bit = gnms_pkg::RAD_W'(1) << bit_pos;
  assign trial    = {1'b0, root_r} + {1'b0, root_bit};
  assign mag_src  = root_r[gnms_pkg::NORM_W-1:0];
  assign mag_sat  = (root_r[gnms_pkg::RAD_W-1:16] != '0) ? 8'hFF : root_r[15:8];

  always_ff @(posedge clk) begin
    if (cmd.root_ld) begin
      rem_r  <= radicand;
      root_r <= '0;
    end else if (cmd.root_step) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r  <= gnms_pkg::RAD_W'({1'b0, rem_r} - trial);
        root_r <= (root_r >> 1) + root_bit;
      end else begin
        root_r <= root_r >> 1;
      end
    end
    if (cmd.root_st) begin
      unique case (cmd.root_dst)
        gnms_pkg::DST_N:   n_r <= mag_src;
        gnms_pkg::DST_G:   g_r[cmd.role] <= mag_src;
        default:           mag_r <= mag_sat;
      endcase
    end
  end

  // vectoring CORDIC
  logic signed [gnms_pkg::CORD_W-1:0] x_r, y_r, sx, sy;
  logic signed [gnms_pkg::ANG_W-1:0]  z_r, z_pos, z_ref, z_fin;
  logic [7:0]                         ori_k, ori;

  assign sx = x_r >>> cmd.step;
  assign sy = y_r >>> cmd.step;

  always_ff @(posedge clk) begin
    if (cmd.cord_ld) begin
      x_r <= gnms_pkg::CORD_W'({c_ax_r, 14'd0});
      y_r <= gnms_pkg::CORD_W'({c_ay_r, 14'd0});
      z_r <= '0;
    end else if (cmd.cord_step && (y_r != '0)) begin
      if (!y_r[gnms_pkg::CORD_W-1]) begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + gnms_pkg::atan_unit(cmd.step);
      end else begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - gnms_pkg::atan_unit(cmd.step);
      end
    end
  end

  assign z_pos = (z_r < 0) ? '0 : z_r;
  assign z_ref = c_gx_r[15] ? gnms_pkg::PI_UNITS - z_pos : z_pos;
  assign z_fin = (z_ref < 0) ? '0 : z_ref;
  assign ori_k = z_fin[gnms_pkg::ANG_W-2:16];
  assign ori   = c_gy_r[15] ? (~ori_k + 8'd1) : ori_k;

  // output register
  logic        out_valid_r, out_last_r;
  logic [15:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r <= frame_end;
      unique case (cmd.res_kind)
        gnms_pkg::RES_BORDER: out_data_r <= {8'd0, mag_r};
        gnms_pkg::RES_KEPT:   out_data_r <= {ori, mag_r};
        default:              out_data_r <= 16'd0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign status.emit_go    = emit_go;
  assign status.border     = border;
  assign status.small_grad = (c_ax_r <= 16'd2) && (c_ay_r <= 16'd2);
  assign status.kept       = keep1_r && keep2_r;
  assign status.out_free   = !out_valid_r || out_tready;

endmodule

// ===== rtl/gradient_nonmax_suppression_core.sv =====
// ----------------------------------------------------------------------------
// gradient_nonmax_suppression_core
// Canny non-maximum suppression over a raster stream of Q8.8 gradient pairs.
// ----------------------------------------------------------------------------
// A pixel word that yields no result is accepted while idle. The first
// columns+1 pixels of a stream yield none; after that each pixel word (or a
// flush word while results are pending) yields the result of the oldest
// pending pixel. A near-zero interior pixel needs the center read, squares
// and class check; a border pixel adds the magnitude root; a suppressed one
// adds center and neighbour roots and compare; a kept one also magnitude
// root and angle iteration. Time is set by the one-bit-per-cycle square
// root (21 steps), the single line-store read port and the 20-step angle
// iteration. Line stores hold no reset contents, so there is no clearing
// pass; results wait in an output register while the next word is accepted.
module gradient_nonmax_suppression_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gnms_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [gnms_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // grad_x[15:0], grad_y[31:16]
  input  logic                           in_tuser,   // kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // edge_magnitude[7:0], edge_orientation[15:8]
  output logic                           out_tlast
);

  gnms_pkg::ctrl_cmd_t  cmd;
  gnms_pkg::dp_status_t status;

  gnms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gnms_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .status     (status)
  );

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result register loaded while holding an untaken word");

  a_busy_after_go: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && status.emit_go) |=> !in_tready)
    else $error("input taken while a result is being computed");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");
`endif

endmodule
